// File: hdl/hsv_to_rgb_id_color_macros.svh
// Assertion macros shared by the checker of the HSV to RGB color block.
`ifndef HSV_TO_RGB_ID_COLOR_MACROS_SVH
`define HSV_TO_RGB_ID_COLOR_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define HRGB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("HSV to RGB checker: property violated");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define HRGB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("HSV to RGB checker: property violated");

`endif

// File: hdl/hrgb_pkg.sv
// Shared types and constants for the HSV to RGB color block.
`timescale 1ns / 1ps

package hrgb_pkg;

    localparam logic [16:0] ONE_Q16    = 17'd65536;
    localparam logic [31:0] GOLDEN_Q32 = 32'd2654435769;

    localparam logic [15:0] INITIAL_HUE_RESET = 16'd45220;
    localparam logic [16:0] SATURATION_RESET  = 17'd55706;
    localparam logic [16:0] BRIGHTNESS_RESET  = 17'd50463;

    typedef enum logic [1:0] {
        REG_INITIAL_HUE = 2'd0,
        REG_SATURATION  = 2'd1,
        REG_BRIGHTNESS  = 2'd2
    } reg_addr_t;

    typedef enum logic [2:0] {
        SECTOR_0 = 3'd0,
        SECTOR_1 = 3'd1,
        SECTOR_2 = 3'd2,
        SECTOR_3 = 3'd3,
        SECTOR_4 = 3'd4,
        SECTOR_5 = 3'd5
    } sector_t;

    // Conversion settings as seen by the datapath, saturation and value clamped to 1.0.
    typedef struct packed {
        logic [15:0] initial_hue;
        logic [16:0] sat;
        logic [16:0] val;
    } cfg_t;

    // The four candidate component levels and the sector that orders them.
    typedef struct packed {
        sector_t     sector;
        logic [16:0] v;
        logic [16:0] p;
        logic [16:0] q;
        logic [16:0] t;
    } shade_t;

endpackage

// File: hdl/hrgb_cfg.sv
// Configuration register file with an APB-style access port.
`timescale 1ns / 1ps

module hrgb_cfg
    import hrgb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    logic [15:0] initial_hue_reg;
    logic [16:0] saturation_reg;
    logic [16:0] brightness_reg;
    logic        write_en;
    reg_addr_t   addr;

    assign pready   = 1'b1;
    assign write_en = psel && penable && pwrite;
    assign addr     = reg_addr_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            initial_hue_reg <= INITIAL_HUE_RESET;
            saturation_reg  <= SATURATION_RESET;
            brightness_reg  <= BRIGHTNESS_RESET;
        end
        else if (write_en)
        begin
            unique case (addr)
                REG_INITIAL_HUE: initial_hue_reg <= pwdata[15:0];
                REG_SATURATION:  saturation_reg  <= pwdata[16:0];
                REG_BRIGHTNESS:  brightness_reg  <= pwdata[16:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (addr)
            REG_INITIAL_HUE: prdata = {16'd0, initial_hue_reg};
            REG_SATURATION:  prdata = {15'd0, saturation_reg};
            REG_BRIGHTNESS:  prdata = {15'd0, brightness_reg};
            default:         prdata = 32'd0;
        endcase
    end

    // Values above 1.0 behave as exactly 1.0.
    assign cfg.initial_hue = initial_hue_reg;
    assign cfg.sat = (saturation_reg > ONE_Q16) ? ONE_Q16 : saturation_reg;
    assign cfg.val = (brightness_reg > ONE_Q16) ? ONE_Q16 : brightness_reg;

endmodule

// File: hdl/hrgb_hue.sv
// First pipeline stage: picks the direct hue or derives one from the id.
`timescale 1ns / 1ps

module hrgb_hue
    import hrgb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        command,
    input  logic [30:0] id,
    input  logic [16:0] hue_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] hue_out
);

    logic        valid_reg;
    logic        valid_next;
    logic [15:0] hue_reg;
    logic [15:0] hue_next;
    logic [31:0] spread;
    logic [31:0] acc;

    // Golden-ratio spacing: the product keeps only its low 32 bits.
    assign spread = {1'b0, id} * GOLDEN_Q32;
    assign acc    = {cfg.initial_hue, 16'd0} + spread;

    always_comb
    begin
        if (command)
        begin
            hue_next = hue_in[16] ? 16'd0 : hue_in[15:0];
        end
        else
        begin
            hue_next = acc[31:16];
        end
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            hue_reg <= hue_next;
        end
    end

    assign out_valid = valid_reg;
    assign hue_out   = hue_reg;

endmodule

// File: hdl/hrgb_shade.sv
// Pipeline stages two to four: sector split, inner products, outer products.
`timescale 1ns / 1ps

module hrgb_shade
    import hrgb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] hue,
    output logic        out_valid,
    input  logic        out_ready,
    output shade_t      shade
);

    // Stage two: sector and fraction.
    logic        split_valid_reg;
    logic        split_ready;
    sector_t     split_sector_reg;
    logic [15:0] split_frac_reg;
    logic [18:0] h6;

    // Stage three: the factors that scale the value.
    logic        scale_valid_reg;
    logic        scale_ready;
    sector_t     scale_sector_reg;
    logic [16:0] scale_p_reg;
    logic [16:0] scale_q_reg;
    logic [16:0] scale_t_reg;
    logic [32:0] fs_prod;
    logic [16:0] inv_frac;
    logic [33:0] nfs_prod;

    // Stage four: the levels themselves.
    logic        level_valid_reg;
    logic        level_ready;
    shade_t      level_reg;
    shade_t      level_next;
    logic [33:0] p_prod;
    logic [33:0] q_prod;
    logic [33:0] t_prod;

    assign level_ready = !level_valid_reg || out_ready;
    assign scale_ready = !scale_valid_reg || level_ready;
    assign split_ready = !split_valid_reg || scale_ready;
    assign in_ready    = split_ready;

    assign h6 = {1'b0, hue, 2'b00} + {2'b00, hue, 1'b0};

    assign fs_prod  = 33'({1'b0, split_frac_reg}) * 33'(cfg.sat);
    assign inv_frac = ONE_Q16 - {1'b0, split_frac_reg};
    assign nfs_prod = 34'(inv_frac) * 34'(cfg.sat);

    assign p_prod = 34'(cfg.val) * 34'(scale_p_reg);
    assign q_prod = 34'(cfg.val) * 34'(scale_q_reg);
    assign t_prod = 34'(cfg.val) * 34'(scale_t_reg);

    always_comb
    begin
        level_next.sector = scale_sector_reg;
        level_next.v      = cfg.val;
        level_next.p      = p_prod[32:16];
        level_next.q      = q_prod[32:16];
        level_next.t      = t_prod[32:16];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            split_valid_reg <= 1'b0;
            scale_valid_reg <= 1'b0;
            level_valid_reg <= 1'b0;
        end
        else
        begin
            if (split_ready)
            begin
                split_valid_reg <= in_valid;
            end
            if (scale_ready)
            begin
                scale_valid_reg <= split_valid_reg;
            end
            if (level_ready)
            begin
                level_valid_reg <= scale_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (split_ready && in_valid)
        begin
            split_sector_reg <= sector_t'(h6[18:16]);
            split_frac_reg   <= h6[15:0];
        end
        if (scale_ready && split_valid_reg)
        begin
            scale_sector_reg <= split_sector_reg;
            scale_p_reg      <= ONE_Q16 - cfg.sat;
            scale_q_reg      <= ONE_Q16 - fs_prod[32:16];
            scale_t_reg      <= ONE_Q16 - nfs_prod[32:16];
        end
        if (level_ready && scale_valid_reg)
        begin
            level_reg <= level_next;
        end
    end

    assign out_valid = level_valid_reg;
    assign shade     = level_reg;

endmodule

// File: hdl/hsv_to_rgb_id_color.sv
// Top level of the HSV to RGB color block: pipeline, register port and output register.
`timescale 1ns / 1ps
// An accepted input word passes through the hue, split, scale and level registers, then the output register.
// Throughput: one word per cycle; each stage moves on whenever the stage after it can take.
// A stall on the output side holds each full stage and moves bubbles forward.
// Reset (rst_n low, asynchronous) empties every stage and loads the register defaults.

module hsv_to_rgb_id_color
    import hrgb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        command,
    input  logic [30:0] id,
    input  logic [16:0] hue,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [16:0] red,
    output logic [16:0] green,
    output logic [16:0] blue
);

    cfg_t        cfg;
    logic        hue_ready;
    logic        hue_valid;
    logic [15:0] hue_frac;
    logic        shade_ready;
    logic        shade_valid;
    shade_t      shade;
    logic        out_valid_reg;
    logic        out_ready;
    logic [16:0] red_next;
    logic [16:0] green_next;
    logic [16:0] blue_next;
    logic [16:0] red_reg;
    logic [16:0] green_reg;
    logic [16:0] blue_reg;

    // The user must change register settings only while the pipeline is empty (the block does not enforce this),
    // so the stages read them directly instead of carrying a copy with each word.
    hrgb_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Stage one resolves the hue, either as given or from the golden-ratio sequence.
    hrgb_hue u_hue (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_ready  (hue_ready),
        .command   (command),
        .id        (id),
        .hue_in    (hue),
        .out_valid (hue_valid),
        .out_ready (shade_ready),
        .hue_out   (hue_frac)
    );

    // Stages two to four compute the value and the three derived levels.
    hrgb_shade u_shade (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (hue_valid),
        .in_ready  (shade_ready),
        .hue       (hue_frac),
        .out_valid (shade_valid),
        .out_ready (out_ready),
        .shade     (shade)
    );

    assign in_stall = !hue_ready;

    // The sector decides which level drives each channel.
    always_comb
    begin
        unique case (shade.sector)
            SECTOR_0:
            begin
                red_next   = shade.v;
                green_next = shade.t;
                blue_next  = shade.p;
            end
            SECTOR_1:
            begin
                red_next   = shade.q;
                green_next = shade.v;
                blue_next  = shade.p;
            end
            SECTOR_2:
            begin
                red_next   = shade.p;
                green_next = shade.v;
                blue_next  = shade.t;
            end
            SECTOR_3:
            begin
                red_next   = shade.p;
                green_next = shade.q;
                blue_next  = shade.v;
            end
            SECTOR_4:
            begin
                red_next   = shade.t;
                green_next = shade.p;
                blue_next  = shade.v;
            end
            default:
            begin
                red_next   = shade.v;
                green_next = shade.p;
                blue_next  = shade.q;
            end
        endcase
    end

    // Output register: it takes a new word whenever it is empty or its word leaves.
    assign out_ready = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= shade_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && shade_valid)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;

endmodule

// File: hdl/hrgb_checker.sv
// Port-level checker for the HSV to RGB color block, bound to the top level.
`timescale 1ns / 1ps
`include "hsv_to_rgb_id_color_macros.svh"

module hrgb_checker
    import hrgb_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [3:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall
);

    logic in_take;
    logic hue_write;
    logic hue_read;

    assign in_take   = in_valid && !in_stall;
    assign hue_write = psel && penable && pwrite && pready && (paddr[3:2] == REG_INITIAL_HUE);
    assign hue_read  = (paddr[3:2] == REG_INITIAL_HUE);

    // A result word waiting on a stall stays offered.
    `HRGB_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

    // With the output side free, every stage can move, so the input never stalls.
    `HRGB_ASSERT_NOW(a_no_stall_back, !out_stall, !in_stall)

    // An accepted word reaches the output when the output side stays free.
    `HRGB_ASSERT_NEXT(a_latency, (in_take && !out_stall) ##1 !out_stall [*4], out_valid)

    // A write to the hue offset reads back on the next cycle.
    `HRGB_ASSERT_NOW(a_cfg_readback, hue_write ##1 hue_read, prdata == {16'd0, $past(pwdata[15:0])})

endmodule

bind hsv_to_rgb_id_color hrgb_checker u_hrgb_checker (.*);
